// File: sv/lattice_random_walk_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lattice random walk step block
// Short forms of the concurrent assertions, sampled on clk and off in reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_RANDOM_WALK_STEP_MACROS_SVH
`define LATTICE_RANDOM_WALK_STEP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define LRWS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LRWS_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: sv/lrws_pkg.sv
// ----------------------------------------------------------------------------
// lrws_pkg
// Constants, codes and types of the lattice random walk step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrws_pkg;

	localparam int NUM_CELLS     = 13;
	localparam int LATTICE_SITES = 1024;
	localparam int COUNT_WIDTH   = 20;

	localparam int POS_W      = 10;
	localparam int PROB_W     = 16;
	localparam int LEN_CFG_W  = 6;
	localparam int CELL_W     = LEN_CFG_W + 1;
	localparam int CNT_OUT_W  = 20;
	localparam int SUM_W      = 30;
	localparam int SQ_W       = 40;
	localparam int SQ_PROD_W  = 2 * POS_W;
	localparam int MODE_W     = 2;

	localparam int IN_FIELDS_W  = POS_W + PROB_W + PROB_W + POS_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = POS_W + CNT_OUT_W + SUM_W + SQ_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = PROB_W;

	localparam int HIST_AW   = $clog2(LATTICE_SITES);
	localparam int LEN_W     = $clog2((1 << CELL_W) * NUM_CELLS + LATTICE_SITES + 1);
	localparam int DIV_CNT_W = $clog2(POS_W);

	typedef enum logic [MODE_W-1:0] {
		MODE_STEP  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_LEFT  = 3'd0,
		REG_INNER_RIGHT = 3'd1,
		REG_OUTER_LEFT  = 3'd2,
		REG_OUTER_RIGHT = 3'd3,
		REG_CROSS_OUT   = 3'd4,
		REG_CROSS_IN    = 3'd5,
		REG_INNER_LEN   = 3'd6,
		REG_OUTER_LEN   = 3'd7
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLEAR  = 7'b0000010,
		ST_DIV    = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_RD     = 7'b0010000,
		ST_UPD    = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

endpackage

// File: sv/lattice_random_walk_step.sv
// ----------------------------------------------------------------------------
// lattice_random_walk_step
// One step of a particle random walk on a 1D lattice, with site histogram and
// saturating sums of position and squared position.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready with the mode in s_tuser; one
// result word per input leaves on m_tvalid/m_tready. The block takes one
// word at a time and drops s_tready until that word's result is registered.
// A step on the lattice runs a restoring remainder unit, one bit per cycle,
// to find the site's offset in its unit cell, then the decide, read, update
// and finish states. A step off the lattice or a bin read runs read, update
// and finish, an unused mode only finish, and a clear sweeps all 1024 bins,
// one histogram bin per cycle through the memory write port, then finish.
// After reset the block sweeps all 1024 histogram bins to zero and
// holds s_tready low; configuration writes are taken at any time.
// The result waits in the output register while the receiver stalls; the
// next word may be accepted meanwhile, but its result waits until the
// register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lattice_random_walk_step
	import lrws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position, rnd_move, rnd_cross, bin_index
	input  logic [MODE_W-1:0]     s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // new_position, bin_count, sum_pos, sum_pos_sq
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [PROB_W-1:0]    inner_left_q, inner_right_q, outer_left_q, outer_right_q;
	logic [PROB_W-1:0]    cross_out_q, cross_in_q;
	logic [LEN_CFG_W-1:0] inner_len_q, outer_len_q;

	state_t                state_q;
	mode_t                 mode_q;
	logic [POS_W-1:0]      pos_q, bin_q, dvd_q, site_q;
	logic [PROB_W-1:0]     rmove_q, rcross_q;
	logic [CELL_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [SQ_PROD_W-1:0]  sq_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [HIST_AW-1:0]    clr_addr_q;
	logic                  clr_resp_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sumsq_q;
	logic [POS_W-1:0]      res_pos_q;
	logic [CNT_OUT_W-1:0]  res_cnt_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [COUNT_WIDTH-1:0] hist_mem [LATTICE_SITES];

	logic                  accept;
	logic [CELL_W-1:0]     unit_len;
	logic [LEN_W-1:0]      len_raw, len;
	logic [POS_W-1:0]      in_pos, in_bin;
	logic [PROB_W-1:0]     in_rmove, in_rcross;
	mode_t                 in_mode;
	logic [CELL_W:0]       trial;
	logic                  trial_ge;
	logic [CELL_W-1:0]     rem_next;
	logic                  inner, tinner, go_left, go_right, move_l, move_r, cross_ok, take;
	logic [PROB_W-1:0]     pl, pr;
	logic [PROB_W:0]       plr;
	logic [CELL_W-1:0]     toff;
	logic [POS_W-1:0]      target;
	logic [SUM_W:0]        sum_add;
	logic [SQ_W:0]         sq_add;
	logic                  site_hit, bin_hit;
	logic                  mem_we, mem_re;
	logic [HIST_AW-1:0]    mem_waddr, mem_raddr;
	logic [COUNT_WIDTH-1:0] mem_wdata, cnt_inc;
	logic                  out_free;

	assign in_pos    = s_tdata[POS_W-1:0];
	assign in_rmove  = s_tdata[POS_W +: PROB_W];
	assign in_rcross = s_tdata[POS_W+PROB_W +: PROB_W];
	assign in_bin    = s_tdata[POS_W+2*PROB_W +: POS_W];
	assign in_mode   = mode_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign unit_len = CELL_W'(inner_len_q) + CELL_W'(outer_len_q);
	assign len_raw  = LEN_W'(unit_len) * LEN_W'(NUM_CELLS);
	assign len      = (len_raw > LEN_W'(LATTICE_SITES)) ? LEN_W'(LATTICE_SITES) : len_raw;

	assign trial    = {rem_q, dvd_q[POS_W-1]};
	assign trial_ge = trial >= {1'b0, unit_len};
	assign rem_next = trial_ge ? CELL_W'(trial - {1'b0, unit_len}) : CELL_W'(trial);

	assign inner    = rem_q < CELL_W'(inner_len_q);
	assign pl       = inner ? inner_left_q : outer_left_q;
	assign pr       = inner ? inner_right_q : outer_right_q;
	assign plr      = (PROB_W+1)'(pl) + (PROB_W+1)'(pr);
	assign go_left  = rmove_q < pl;
	assign go_right = !go_left && ((PROB_W+1)'(rmove_q) < plr);
	assign move_l   = go_left && (pos_q != '0);
	assign move_r   = go_right && ((LEN_W'(pos_q) + LEN_W'(1)) < len);
	assign target   = move_l ? pos_q - POS_W'(1) : pos_q + POS_W'(1);

	always_comb begin
		if (move_l) begin
			toff = (rem_q == '0) ? unit_len - CELL_W'(1) : rem_q - CELL_W'(1);
		end else begin
			toff = (rem_q + CELL_W'(1) == unit_len) ? '0 : rem_q + CELL_W'(1);
		end
	end

	assign tinner   = toff < CELL_W'(inner_len_q);
	assign cross_ok = inner ? (rcross_q < cross_out_q) : (rcross_q < cross_in_q);
	assign take     = (move_l || move_r) && ((tinner == inner) || cross_ok);

	assign sum_add  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(site_q);
	assign sq_add   = (SQ_W+1)'(sumsq_q) + (SQ_W+1)'(sq_q);
	assign site_hit = 32'(site_q) < LATTICE_SITES;
	assign bin_hit  = 32'(bin_q) < LATTICE_SITES;
	assign cnt_inc  = (rd_data_q == '1) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1);

	assign mem_we    = (state_q == ST_CLEAR) ||
		((state_q == ST_UPD) && (mode_q == MODE_STEP) && site_hit);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : HIST_AW'(site_q);
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : cnt_inc;
	assign mem_re    = (state_q == ST_RD);
	assign mem_raddr = (mode_q == MODE_READ) ? HIST_AW'(bin_q) : HIST_AW'(site_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= hist_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_left_q  <= PROB_W'(13107);
			inner_right_q <= PROB_W'(13107);
			outer_left_q  <= PROB_W'(19661);
			outer_right_q <= PROB_W'(19661);
			cross_out_q   <= PROB_W'(3277);
			cross_in_q    <= PROB_W'(2185);
			inner_len_q   <= LEN_CFG_W'(11);
			outer_len_q   <= LEN_CFG_W'(11);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_INNER_LEFT:  inner_left_q  <= cfg_data;
				REG_INNER_RIGHT: inner_right_q <= cfg_data;
				REG_OUTER_LEFT:  outer_left_q  <= cfg_data;
				REG_OUTER_RIGHT: outer_right_q <= cfg_data;
				REG_CROSS_OUT:   cross_out_q   <= cfg_data;
				REG_CROSS_IN:    cross_in_q    <= cfg_data;
				REG_INNER_LEN:   inner_len_q   <= cfg_data[LEN_CFG_W-1:0];
				REG_OUTER_LEN:   outer_len_q   <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q     <= in_pos;
			rmove_q   <= in_rmove;
			rcross_q  <= in_rcross;
			bin_q     <= in_bin;
			site_q    <= in_pos;
			dvd_q     <= in_pos;
			rem_q     <= '0;
			res_pos_q <= '0;
			res_cnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
		end
		if (state_q == ST_DECIDE && take) begin
			site_q <= target;
		end
		if (state_q == ST_RD) begin
			sq_q <= SQ_PROD_W'(site_q) * SQ_PROD_W'(site_q);
		end
		if (state_q == ST_UPD) begin
			if (mode_q == MODE_READ) begin
				res_cnt_q <= bin_hit ? CNT_OUT_W'(rd_data_q) : '0;
			end else begin
				res_pos_q <= site_q;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= (mode_q == MODE_NOP) ? '0 :
				OUT_DATA_W'({sumsq_q, sum_q, res_cnt_q, res_pos_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			mode_q     <= MODE_NOP;
			div_cnt_q  <= '0;
			clr_addr_q <= '0;
			clr_resp_q <= 1'b0;
			sum_q      <= '0;
			sumsq_q    <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= in_mode;
						case (in_mode)
							MODE_STEP: begin
								div_cnt_q <= '0;
								state_q   <= (LEN_W'(in_pos) < len) ? ST_DIV : ST_RD;
							end
							MODE_READ: state_q <= ST_RD;
							MODE_CLEAR: begin
								sum_q      <= '0;
								sumsq_q    <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + HIST_AW'(1);
					if (clr_addr_q == HIST_AW'(LATTICE_SITES - 1)) begin
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(POS_W - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: state_q <= ST_RD;
				ST_RD:     state_q <= ST_UPD;
				ST_UPD: begin
					if (mode_q == MODE_STEP) begin
						sum_q   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
						sumsq_q <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: sv/lrws_checker.sv
// ----------------------------------------------------------------------------
// lrws_checker
// Port-level assertions for the lattice random walk step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lattice_random_walk_step_macros.svh"

module lrws_checker
	import lrws_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata    // new_position, bin_count, sum_pos, sum_pos_sq
);

	// A stalled result word stays on the bus.
	`LRWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

	// Every word moves the sequencer out of idle, so the input closes after it is taken.
	`LRWS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input open right after a word")

	// A result is released only as the sequencer returns to idle.
	`LRWS_ASSERT_SAME(a_result_at_idle, $rose(m_tvalid), s_tready, "result released while busy")

	// A step result carries no bin count, and a read result carries no position.
	`LRWS_ASSERT_SAME(a_fields_exclusive, m_tvalid && (m_tdata[9:0] != 10'd0), m_tdata[29:10] == 20'd0, "position and bin count both set")

endmodule

bind lattice_random_walk_step lrws_checker u_lrws_checker (.*);

// File: dv/lattice_walk_checker.sv
// ----------------------------------------------------------------------------
// Lattice walk checker
// Watches the input, result and register ports of the random walk step block.
// It keeps its own copy of the registers, the site histogram and the position
// sums, works out the result word of every accepted input word, and compares
// each result word field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lattice_walk_checker
	import lrws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    checked,
	output int                    crossings,
	output int                    stranded
);

	typedef longint unsigned u64_t;

	typedef struct {
		bit [POS_W-1:0]     new_position;
		bit [CNT_OUT_W-1:0] bin_count;
		bit [SUM_W-1:0]     sum_pos;
		bit [SQ_W-1:0]      sum_pos_sq;
	} walk_result_t;

	localparam u64_t SUM_CAP = (64'd1 << SUM_W) - 1;
	localparam u64_t SQ_CAP  = (64'd1 << SQ_W) - 1;
	localparam bit [COUNT_WIDTH-1:0] COUNT_CAP = '1;

	bit [PROB_W-1:0]      inner_left, inner_right, outer_left, outer_right;
	bit [PROB_W-1:0]      cross_out, cross_in;
	bit [LEN_CFG_W-1:0]   inner_len, outer_len;
	bit [COUNT_WIDTH-1:0] site_count [LATTICE_SITES];
	u64_t                 pos_total, sq_total;
	walk_result_t         awaited_results [$];
	int                   err_count, checked_count, crossings_seen, stranded_steps;

	function automatic void clear_tallies();
		foreach (site_count[i])
			site_count[i] = '0;
		pos_total = 0;
		sq_total = 0;
	endfunction

	function automatic void restore_defaults();
		inner_left = 16'd13107;
		inner_right = 16'd13107;
		outer_left = 16'd19661;
		outer_right = 16'd19661;
		cross_out = 16'd3277;
		cross_in = 16'd2185;
		inner_len = 6'd11;
		outer_len = 6'd11;
		clear_tallies();
	endfunction

	// With no unit cell at all every site counts as outer.
	function automatic bit is_inner(int unsigned site, int unsigned unit_len);
		int unsigned offset;
		offset = (unit_len == 0) ? 0 : site % unit_len;
		return offset < inner_len;
	endfunction

	function automatic void record_site(int unsigned site);
		u64_t wide_site;
		wide_site = site;
		pos_total = pos_total + wide_site;
		if (pos_total > SUM_CAP)
			pos_total = SUM_CAP;
		sq_total = sq_total + wide_site * wide_site;
		if (sq_total > SQ_CAP)
			sq_total = SQ_CAP;
		if (site < LATTICE_SITES && site_count[site] != COUNT_CAP)
			site_count[site]++;
	endfunction

	function automatic walk_result_t next_site_result(mode_t mode, bit [POS_W-1:0] position,
			bit [PROB_W-1:0] rnd_move, bit [PROB_W-1:0] rnd_cross, bit [POS_W-1:0] bin_index);
		walk_result_t res;
		int unsigned unit_len, span, site, target, left_p, right_p;
		bit from_inner, moved;
		res = '{default: '0};
		case (mode)
			MODE_STEP: begin
				unit_len = inner_len + outer_len;
				span = unit_len * NUM_CELLS;
				if (span > LATTICE_SITES)
					span = LATTICE_SITES;
				site = position;
				target = position;
				moved = 1'b0;
				if (position < span) begin
					from_inner = is_inner(position, unit_len);
					left_p = from_inner ? inner_left : outer_left;
					right_p = from_inner ? inner_right : outer_right;
					if (rnd_move < left_p) begin
						if (position > 0) begin
							target = position - 1;
							moved = 1'b1;
						end
					end else if (rnd_move < left_p + right_p) begin
						if (position + 1 < span) begin
							target = position + 1;
							moved = 1'b1;
						end
					end
					if (moved) begin
						if (is_inner(target, unit_len) == from_inner) begin
							site = target;
						end else if (rnd_cross < (from_inner ? cross_out : cross_in)) begin
							site = target;
							crossings_seen++;
						end
					end
				end else begin
					stranded_steps++;
				end
				record_site(site);
				res.new_position = POS_W'(site);
			end
			MODE_READ: begin
				if (bin_index < LATTICE_SITES)
					res.bin_count = CNT_OUT_W'(site_count[bin_index]);
			end
			MODE_CLEAR: begin
				clear_tallies();
			end
			MODE_NOP: begin
				return res;
			end
		endcase
		res.sum_pos = SUM_W'(pos_total);
		res.sum_pos_sq = SQ_W'(sq_total);
		return res;
	endfunction

	function automatic void compare_field(string field, u64_t want, u64_t got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		walk_result_t want, got;
		if (!arst_n) begin
			restore_defaults();
			awaited_results.delete();
			err_count = 0;
			checked_count = 0;
			crossings_seen = 0;
			stranded_steps = 0;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
			crossings <= 0;
			stranded <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.new_position = m_tdata[POS_W-1:0];
				got.bin_count = m_tdata[POS_W +: CNT_OUT_W];
				got.sum_pos = m_tdata[POS_W+CNT_OUT_W +: SUM_W];
				got.sum_pos_sq = m_tdata[POS_W+CNT_OUT_W+SUM_W +: SQ_W];
				if ($isunknown(m_tdata)) begin
					err_count++;
					$display("%0t: result word has unknown bits: %h", $time, m_tdata);
				end
				if (awaited_results.size() == 0) begin
					err_count++;
					$display("%0t: result word with nothing expected: position %0d count %0d",
						$time, got.new_position, got.bin_count);
				end else begin
					want = awaited_results.pop_front();
					checked_count++;
					compare_field("new_position", want.new_position, got.new_position);
					compare_field("bin_count", want.bin_count, got.bin_count);
					compare_field("sum_pos", want.sum_pos, got.sum_pos);
					compare_field("sum_pos_sq", want.sum_pos_sq, got.sum_pos_sq);
				end
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(next_site_result(mode_t'(s_tuser),
					s_tdata[POS_W-1:0], s_tdata[POS_W +: PROB_W],
					s_tdata[POS_W+PROB_W +: PROB_W], s_tdata[POS_W+2*PROB_W +: POS_W]));
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_INNER_LEFT:  inner_left = cfg_data;
					REG_INNER_RIGHT: inner_right = cfg_data;
					REG_OUTER_LEFT:  outer_left = cfg_data;
					REG_OUTER_RIGHT: outer_right = cfg_data;
					REG_CROSS_OUT:   cross_out = cfg_data;
					REG_CROSS_IN:    cross_in = cfg_data;
					REG_INNER_LEN:   inner_len = cfg_data[LEN_CFG_W-1:0];
					REG_OUTER_LEN:   outer_len = cfg_data[LEN_CFG_W-1:0];
				endcase
			end
			mismatches <= err_count;
			pending <= awaited_results.size();
			checked <= checked_count;
			crossings <= crossings_seen;
			stranded <= stranded_steps;
		end
	end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Random walk step testbench
// Drives input words and register writes into the lattice random walk step
// block and lets the lattice walk checker predict and compare every result
// word. A short directed sequence at reset settings is followed by random
// words under a series of register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import lrws_pkg::*;

	localparam int STALL_LIMIT     = 5000;
	localparam int PHASES          = 10;
	localparam int WORDS_PER_PHASE = 108;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches, pending, checked, crossings, stranded;
	int quiet_cycles = 0;
	int stall_left = 0;
	int words_sent = 0;
	bit steady = 1'b0;
	bit [CFG_DATA_W-1:0] shadow [8] = '{13107, 13107, 19661, 19661, 3277, 2185, 11, 11};

	lattice_random_walk_step DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lattice_walk_checker u_walk_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.crossings(crossings), .stranded(stranded)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin : result_stalls
		int r;
		if (stall_left > 0 && !steady) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			r = $urandom_range(0, 99);
			if (steady)
				stall_left = 0;
			else if (r < 20)
				stall_left = $urandom_range(1, 3);
			else if (r < 23)
				stall_left = $urandom_range(15, 60);
			else
				stall_left = 0;
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic bit [PROB_W-1:0] clamp_fraction(int value);
		if (value < 0)
			return '0;
		if (value > 65535)
			return '1;
		return PROB_W'(value);
	endfunction

	// Sites are taken mostly on the lattice, with many right at a region boundary.
	function automatic bit [POS_W-1:0] pick_site(int unsigned unit_len, int unsigned span);
		int r, site;
		r = $urandom_range(0, 99);
		if (span == 0 || r < 15)
			return POS_W'($urandom);
		if (r < 22) begin
			case ($urandom_range(0, 3))
				0: site = 0;
				1: site = span - 1;
				2: site = span;
				default: site = LATTICE_SITES - 1;
			endcase
		end else if (r < 60) begin
			site = unit_len * $urandom_range(0, NUM_CELLS)
				+ ($urandom_range(0, 1) ? shadow[REG_INNER_LEN] : 0) - $urandom_range(0, 1);
			if (site < 0)
				site = 0;
		end else begin
			site = $urandom_range(0, span - 1);
		end
		return POS_W'(site);
	endfunction

	task automatic send_word(mode_t mode, bit [POS_W-1:0] position, bit [PROB_W-1:0] rnd_move,
			bit [PROB_W-1:0] rnd_cross, bit [POS_W-1:0] bin_index);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = IN_DATA_W'({bin_index, rnd_cross, rnd_move, position});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, bit [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		shadow[idx] = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(int setting);
		bit [CFG_DATA_W-1:0] value [8];
		foreach (value[r])
			value[r] = CFG_DATA_W'($urandom);
		value[REG_INNER_LEN] = CFG_DATA_W'($urandom_range(1, 32));
		value[REG_OUTER_LEN] = CFG_DATA_W'($urandom_range(1, 32));
		case (setting)
			0: begin
				foreach (value[r])
					value[r] = '0;
				value[REG_INNER_LEN] = 1;
				value[REG_OUTER_LEN] = 1;
			end
			1: begin
				foreach (value[r])
					value[r] = '1;
				value[REG_INNER_LEN] = 32;
				value[REG_OUTER_LEN] = 32;
			end
			2: begin
				value[REG_INNER_LEFT] = '0;
				value[REG_INNER_RIGHT] = '1;
				value[REG_OUTER_LEFT] = '1;
				value[REG_OUTER_RIGHT] = '0;
				value[REG_INNER_LEN] = 1;
				value[REG_OUTER_LEN] = 32;
			end
			3: begin
				value[REG_INNER_LEN] = 0;
				value[REG_OUTER_LEN] = 0;
			end
			4: begin
				value[REG_INNER_LEN] = 63;
				value[REG_OUTER_LEN] = 63;
			end
			5: value[REG_INNER_LEN] = 0;
			6: value[REG_OUTER_LEN] = 0;
			default: ;
		endcase
		foreach (value[r])
			write_reg(reg_idx_t'(r), value[r]);
	endtask

	task automatic send_random_word();
		int unsigned unit_len, span, pick;
		int base;
		mode_t mode;
		bit [PROB_W-1:0] rnd_move, rnd_cross;
		bit [POS_W-1:0] bin_index;
		unit_len = shadow[REG_INNER_LEN] + shadow[REG_OUTER_LEN];
		span = unit_len * NUM_CELLS;
		if (span > LATTICE_SITES)
			span = LATTICE_SITES;
		pick = $urandom_range(0, 99);
		if (pick == 0)
			mode = MODE_CLEAR;
		else if (pick < 5)
			mode = MODE_NOP;
		else if (pick < 20)
			mode = MODE_READ;
		else
			mode = MODE_STEP;
		case ($urandom_range(0, 3))
			0: base = shadow[REG_INNER_LEFT];
			1: base = shadow[REG_OUTER_LEFT];
			2: base = shadow[REG_INNER_LEFT] + shadow[REG_INNER_RIGHT];
			default: base = shadow[REG_OUTER_LEFT] + shadow[REG_OUTER_RIGHT];
		endcase
		rnd_move = $urandom_range(0, 1) ? PROB_W'($urandom) :
			clamp_fraction(base - $urandom_range(0, 1));
		base = $urandom_range(0, 1) ? shadow[REG_CROSS_OUT] : shadow[REG_CROSS_IN];
		rnd_cross = $urandom_range(0, 1) ? PROB_W'($urandom) :
			clamp_fraction(base - $urandom_range(0, 1));
		bin_index = $urandom_range(0, 1) ? POS_W'($urandom) : pick_site(unit_len, span);
		send_word(mode, pick_site(unit_len, span), rnd_move, rnd_cross, bin_index);
	endtask

	initial begin : stimulus
		int phase, i;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: unit cell of 22 sites, 286 sites on the lattice.
		send_word(MODE_STEP, 0, 0, 0, 0);
		send_word(MODE_STEP, 285, 19661, 0, 0);
		send_word(MODE_STEP, 5, 0, 0, 0);
		send_word(MODE_STEP, 5, 26213, 0, 0);
		send_word(MODE_STEP, 5, 26214, 0, 0);
		send_word(MODE_STEP, 5, 16'hFFFF, 0, 0);
		send_word(MODE_STEP, 10, 13107, 3276, 0);
		send_word(MODE_STEP, 10, 13107, 3277, 0);
		send_word(MODE_STEP, 11, 19660, 2184, 0);
		send_word(MODE_STEP, 11, 0, 2185, 0);
		send_word(MODE_STEP, 21, 39321, 0, 0);
		send_word(MODE_STEP, 22, 13106, 0, 0);
		send_word(MODE_STEP, 286, 0, 0, 0);
		send_word(MODE_STEP, 10'h3FF, 16'hFFFF, 16'hFFFF, 10'h3FF);
		send_word(MODE_READ, 0, 0, 0, 10'h3FF);
		send_word(MODE_READ, 10'h3FF, 16'hFFFF, 16'hFFFF, 0);
		send_word(MODE_READ, 0, 0, 0, 11);
		send_word(MODE_NOP, 10'h3FF, 16'hFFFF, 16'hFFFF, 10'h3FF);
		send_word(MODE_CLEAR, 0, 0, 0, 0);
		send_word(MODE_READ, 0, 0, 0, 10'h3FF);
		send_word(MODE_STEP, 600, 0, 0, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_setting(phase);
			steady = (phase % 4 == 3);
			for (i = 0; i < WORDS_PER_PHASE; i++) begin
				send_random_word();
				if (i == WORDS_PER_PHASE / 2 && phase % 3 == 1)
					drain();
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d words over %0d register settings, %0d result words checked.",
			words_sent, PHASES + 1, checked);
		$display("Accepted boundary crossings: %0d, steps from off the lattice: %0d.",
			crossings, stranded);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
